FILE: rtl/smuc_pkg.sv
// Shared types and constants for the sorted merge with unknown compaction.
// Used by smuc_front, smuc_cmdq, smuc_back and the top level; no dependencies.
package smuc_pkg;

    localparam int SEQ_W    = 15;
    localparam int LOC_W    = 31;
    localparam int KEY_W    = SEQ_W + LOC_W;
    localparam int ALLELE_W = 8;
    localparam int PROD_W   = 8;
    localparam int STRAIN_W = 15;

    typedef logic [KEY_W-1:0] key_t;

    // Previous key after reset: no key seen yet
    localparam key_t NO_KEY = '1;

    // Input operation codes
    localparam logic [1:0] OP_ROW_A = 2'd0;
    localparam logic [1:0] OP_ROW_B = 2'd1;
    localparam logic [1:0] OP_END_A = 2'd2;
    localparam logic [1:0] OP_END_B = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_ALLELE  = 2'd0;
    localparam logic [1:0] KIND_UNKNOWN = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    localparam logic signed [PROD_W-1:0] PRODUCT_COUNT = -8'sd1;
    localparam logic [STRAIN_W-1:0]      COUNT_MAX     = '1;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        CMD_ROW    = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_REJECT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic                        end_item;
        key_t                        key;
        logic [ALLELE_W-1:0]         allele;
        logic signed [PROD_W-1:0]    product;
        logic [STRAIN_W-1:0]         strain;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                  kind;
        key_t                        key;
        logic [ALLELE_W-1:0]         allele;
        logic signed [PROD_W-1:0]    product;
        logic [STRAIN_W-1:0]         strain;
        logic                        last;
    } res_t;

    typedef struct packed {
        logic [STRAIN_W-1:0]         strain_a;
        logic [STRAIN_W-1:0]         strain_b;
    } cfg_t;

endpackage

FILE: rtl/smuc_front.sv
// Front end: accepts items, keeps the two head rows and the end marks,
// and issues merge commands in order. Depends on smuc_pkg.
module smuc_front
    import smuc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  op,
    input  logic [SEQ_W-1:0]            seq,
    input  logic [LOC_W-1:0]            loc,
    input  logic [ALLELE_W-1:0]         allele,
    input  logic signed [PROD_W-1:0]    product,
    input  logic [STRAIN_W-1:0]         strain,
    input  cfg_t                        cfg,
    input  logic                        q_full,
    output logic                        q_push,
    output cmd_t                        q_data
);

    logic [1:0]                 hv_reg, hv_next;
    logic [1:0]                 ended_reg, ended_next;
    key_t                       hkey_reg [2];
    logic [ALLELE_W-1:0]        hallele_reg [2];
    logic signed [PROD_W-1:0]   hprod_reg [2];
    logic [STRAIN_W-1:0]        hstrain_reg [2];

    logic                       b_first;
    logic                       proc_valid;
    logic                       proc_sel;
    logic                       fin_cond;
    logic                       work;
    logic [1:0]                 hv_after;
    logic                       work_after;
    logic                       accept;
    logic                       side;
    logic                       is_row;
    logic                       reject;
    logic [STRAIN_W-1:0]        sub_strain;
    logic [STRAIN_W-1:0]        row_strain;

    function automatic logic pending(input logic [1:0] v, input logic [1:0] e);
        pending = (v[0] && v[1]) || (v[0] && e[1]) || (v[1] && e[0])
               || (e[0] && e[1] && !v[0] && !v[1]);
    endfunction

    // Merge decision: smaller key first, A on a tie
    always_comb
    begin
        b_first    = hkey_reg[1] < hkey_reg[0];
        proc_valid = 1'b0;
        proc_sel   = 1'b0;
        if (hv_reg[0] && hv_reg[1])
        begin
            proc_valid = 1'b1;
            proc_sel   = b_first;
        end
        else if (hv_reg[0] && ended_reg[1])
        begin
            proc_valid = 1'b1;
            proc_sel   = 1'b0;
        end
        else if (hv_reg[1] && ended_reg[0])
        begin
            proc_valid = 1'b1;
            proc_sel   = 1'b1;
        end
        fin_cond   = ended_reg[0] && ended_reg[1] && !hv_reg[0] && !hv_reg[1];
        work       = proc_valid || fin_cond;
        hv_after   = hv_reg & (proc_sel ? 2'b01 : 2'b10);
        work_after = pending(hv_after, ended_reg);
    end

    assign full       = work || q_full;
    assign accept     = push && !full;
    assign side       = op[0];
    assign is_row     = (op == OP_ROW_A) || (op == OP_ROW_B);
    assign reject     = is_row ? (hv_reg[side] || ended_reg[side]) : ended_reg[side];
    assign sub_strain = side ? cfg.strain_b : cfg.strain_a;
    assign row_strain = (sub_strain != '0) ? sub_strain : strain;

    always_comb
    begin
        q_push     = 1'b0;
        q_data     = '0;
        hv_next    = hv_reg;
        ended_next = ended_reg;
        if (work)
        begin
            if (!q_full)
            begin
                q_push = 1'b1;
                if (proc_valid)
                begin
                    q_data.kind     = CMD_ROW;
                    q_data.end_item = !work_after;
                    q_data.key      = proc_sel ? hkey_reg[1] : hkey_reg[0];
                    q_data.allele   = proc_sel ? hallele_reg[1] : hallele_reg[0];
                    q_data.product  = proc_sel ? hprod_reg[1] : hprod_reg[0];
                    q_data.strain   = proc_sel ? hstrain_reg[1] : hstrain_reg[0];
                    hv_next         = hv_after;
                end
                else
                begin
                    q_data.kind     = CMD_FLUSH;
                    q_data.end_item = 1'b1;
                    q_data.key      = NO_KEY;
                    ended_next      = 2'b00;
                end
            end
        end
        else if (accept)
        begin
            if (reject)
            begin
                q_push          = 1'b1;
                q_data.kind     = CMD_REJECT;
                q_data.end_item = 1'b1;
                q_data.key      = {seq, loc};
                q_data.allele   = allele;
                q_data.product  = product;
                q_data.strain   = strain;
            end
            else if (is_row)
            begin
                hv_next[side] = 1'b1;
            end
            else
            begin
                ended_next[side] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg    <= 2'b00;
            ended_reg <= 2'b00;
        end
        else
        begin
            hv_reg    <= hv_next;
            ended_reg <= ended_next;
        end
    end

    // Head payload: load on a granted row, no reset
    always_ff @(posedge clk)
    begin
        if (!work && accept && !reject && is_row)
        begin
            if (side)
            begin
                hkey_reg[1]    <= {seq, loc};
                hallele_reg[1] <= allele;
                hprod_reg[1]   <= product;
                hstrain_reg[1] <= row_strain;
            end
            else
            begin
                hkey_reg[0]    <= {seq, loc};
                hallele_reg[0] <= allele;
                hprod_reg[0]   <= product;
                hstrain_reg[0] <= row_strain;
            end
        end
    end

endmodule

FILE: rtl/smuc_cmdq.sv
// Two-entry command queue between the front and the back.
// Depends on smuc_pkg for the command type.
module smuc_cmdq
    import smuc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  cmd_t    wr_data,
    output logic    full,
    input  logic    rd_en,
    output cmd_t    rd_data,
    output logic    empty
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/smuc_back.sv
// Back end: carries out merge commands, compacts unknown rows per key and
// queues results with the end-of-item mark. Depends on smuc_pkg.
module smuc_back
    import smuc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    input  logic    cmd_empty,
    output logic    cmd_pop,
    input  logic    pop,
    output logic    empty,
    output res_t    res
);

    key_t                   prev_key_reg, prev_key_next;
    logic [STRAIN_W-1:0]    count_reg, count_next;
    logic                   hold_valid_reg, hold_valid_next;
    res_t                   hold_reg, hold_next;
    logic                   drain_reg, drain_next;

    res_t                   omem_reg [2];
    logic                   owr_ptr_reg;
    logic                   ord_ptr_reg;
    logic [1:0]             ocnt_reg;

    logic                   ospace;
    logic                   o_push;
    res_t                   o_data;
    logic                   o_pop;

    logic                   key_diff;
    logic [STRAIN_W-1:0]    base;
    logic [STRAIN_W:0]      sum;
    logic [STRAIN_W-1:0]    sat_count;
    res_t                   flush_res;
    res_t                   row_res;
    res_t                   rej_res;
    res_t                   cand;
    logic                   cv;
    logic                   fin;
    logic                   fin_item;

    assign empty  = (ocnt_reg == 2'd0);
    assign o_pop  = pop && !empty;
    assign ospace = (ocnt_reg != 2'd2) || pop;
    assign res    = omem_reg[ord_ptr_reg];

    always_comb
    begin
        key_diff  = cmd.key != prev_key_reg;
        base      = key_diff ? '0 : count_reg;
        sum       = {1'b0, base} + ((cmd.product == PRODUCT_COUNT)
                    ? {1'b0, cmd.strain} : {{STRAIN_W{1'b0}}, 1'b1});
        sat_count = sum[STRAIN_W] ? COUNT_MAX : sum[STRAIN_W-1:0];

        flush_res = '{kind: KIND_UNKNOWN, key: prev_key_reg, allele: '0,
                      product: PRODUCT_COUNT, strain: count_reg, last: 1'b0};
        row_res   = '{kind: KIND_ALLELE, key: cmd.key, allele: cmd.allele,
                      product: cmd.product, strain: cmd.strain, last: 1'b0};
        rej_res   = '{kind: KIND_REJECT, key: cmd.key, allele: cmd.allele,
                      product: cmd.product, strain: cmd.strain, last: 1'b0};
    end

    always_comb
    begin
        cmd_pop         = 1'b0;
        prev_key_next   = prev_key_reg;
        count_next      = count_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        drain_next      = drain_reg;
        o_push          = 1'b0;
        o_data          = hold_reg;
        cand            = row_res;
        cv              = 1'b0;
        fin             = 1'b0;
        fin_item        = 1'b0;
        if (ospace)
        begin
            if (drain_reg)
            begin
                // close the item: the held result carries the end mark
                o_push          = 1'b1;
                o_data.last     = 1'b1;
                hold_valid_next = 1'b0;
                drain_next      = 1'b0;
            end
            else if (!cmd_empty)
            begin
                case (cmd.kind)
                    CMD_ROW:
                    begin
                        prev_key_next = cmd.key;
                        count_next    = (cmd.allele != '0) ? base : sat_count;
                        if (key_diff && count_reg != '0)
                        begin
                            // flush first; an allele row stays queued and is replayed after the flush
                            cv   = 1'b1;
                            cand = flush_res;
                            fin  = (cmd.allele == '0);
                        end
                        else
                        begin
                            cv   = (cmd.allele != '0);
                            cand = row_res;
                            fin  = 1'b1;
                        end
                    end
                    CMD_FLUSH:
                    begin
                        cv            = (count_reg != '0);
                        cand          = flush_res;
                        prev_key_next = NO_KEY;
                        count_next    = '0;
                        fin           = 1'b1;
                    end
                    CMD_REJECT:
                    begin
                        cv   = 1'b1;
                        cand = rej_res;
                        fin  = 1'b1;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
                cmd_pop  = fin;
                fin_item = fin && cmd.end_item;
                if (cv)
                begin
                    if (hold_valid_reg)
                    begin
                        o_push          = 1'b1;
                        hold_next       = cand;
                        hold_valid_next = 1'b1;
                        drain_next      = fin_item;
                    end
                    else if (fin_item)
                    begin
                        o_push      = 1'b1;
                        o_data      = cand;
                        o_data.last = 1'b1;
                    end
                    else
                    begin
                        hold_next       = cand;
                        hold_valid_next = 1'b1;
                    end
                end
                else if (fin_item && hold_valid_reg)
                begin
                    o_push          = 1'b1;
                    o_data.last     = 1'b1;
                    hold_valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_key_reg   <= NO_KEY;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            drain_reg      <= 1'b0;
            owr_ptr_reg    <= 1'b0;
            ord_ptr_reg    <= 1'b0;
            ocnt_reg       <= 2'd0;
        end
        else
        begin
            prev_key_reg   <= prev_key_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            drain_reg      <= drain_next;
            if (o_push)
            begin
                owr_ptr_reg <= !owr_ptr_reg;
            end
            if (o_pop)
            begin
                ord_ptr_reg <= !ord_ptr_reg;
            end
            ocnt_reg <= ocnt_reg + {1'b0, o_push} - {1'b0, o_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (o_push)
        begin
            omem_reg[owr_ptr_reg] <= o_data;
        end
    end

    a_drain_has_hold: assert property (@(posedge clk) disable iff (!rst_n)
        drain_reg |-> hold_valid_reg)
        else $error("drain pending without a held result");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && !cmd_empty && cmd.kind == CMD_FLUSH)
        |=> (count_reg == '0 && prev_key_reg == NO_KEY))
        else $error("final flush left compaction state behind");

    a_reject_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd_empty && !drain_reg && cmd.kind == CMD_REJECT) |-> !hold_valid_reg)
        else $error("reject reached while an earlier item is still open");

    a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg != 2'd3)
        else $error("result queue count out of range");

endmodule

FILE: rtl/sorted_merge_with_unknown_compaction.sv
// Top level of the two-way sorted merge with unknown-row compaction.
// Holds the APB registers and joins smuc_front, smuc_cmdq and smuc_back (smuc_pkg).
//
// The block merges two key-sorted row streams, A and B, into one stream sorted
// by (seq, loc), A first on a tie, and folds rows with a zero allele into one
// compacted row per key (kind 1, product -1, strain holding the saturated
// count). Input and output both look like queues: an item transfers on push
// with full low, a result on pop with empty low; last marks the final result
// of each input item, and a rejected item gives exactly one kind 2 result that
// echoes its fields. An item that releases heads holds the input after its
// transfer while the front hands each released head to the command queue; a
// row that only parks in its head, and a rejected item, do not hold it; an item
// that ends both streams holds it also for the final flush command. The back
// handles the queued commands in order, replaying an allele row that forces a
// compaction flush ahead of itself, and marks an item's last result in a separate
// step when it follows a held result. The front waits
// for room in the two-entry command queue, the back for room in the two-entry
// result queue, so each side stalls on its own. strain_id_a (0x0) and
// strain_id_b (0x4) replace the strain of accepted rows when nonzero; write
// them only while the block is idle.
module sorted_merge_with_unknown_compaction
    import smuc_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input queue
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  op,
    input  logic [SEQ_W-1:0]            seq,
    input  logic [LOC_W-1:0]            loc,
    input  logic [ALLELE_W-1:0]         allele,
    input  logic signed [PROD_W-1:0]    product,
    input  logic [STRAIN_W-1:0]         strain,
    // result queue
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  kind,
    output logic [SEQ_W-1:0]            out_seq,
    output logic [LOC_W-1:0]            out_loc,
    output logic [ALLELE_W-1:0]         out_allele,
    output logic signed [PROD_W-1:0]    out_product,
    output logic [STRAIN_W-1:0]         out_strain,
    output logic                        last,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam logic REG_STRAIN_A = 1'b0;
    localparam logic REG_STRAIN_B = 1'b1;

    logic [STRAIN_W-1:0]    strain_a_reg;
    logic [STRAIN_W-1:0]    strain_b_reg;
    logic                   cfg_wr;
    cfg_t                   cfg;

    logic                   q_push;
    cmd_t                   q_wr_data;
    logic                   q_full;
    logic                   q_pop;
    cmd_t                   q_rd_data;
    logic                   q_empty;
    res_t                   res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes: address bit 2 picks the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strain_a_reg <= '0;
            strain_b_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_STRAIN_A: strain_a_reg <= pwdata[STRAIN_W-1:0];
                REG_STRAIN_B: strain_b_reg <= pwdata[STRAIN_W-1:0];
                default:      strain_a_reg <= strain_a_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_STRAIN_A: prdata = {{(32-STRAIN_W){1'b0}}, strain_a_reg};
            REG_STRAIN_B: prdata = {{(32-STRAIN_W){1'b0}}, strain_b_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.strain_a = strain_a_reg;
    assign cfg.strain_b = strain_b_reg;

    // Front: accept, reject or park the item and issue merge commands
    smuc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .op      (op),
        .seq     (seq),
        .loc     (loc),
        .allele  (allele),
        .product (product),
        .strain  (strain),
        .cfg     (cfg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    // Hold commands between the two sides
    smuc_cmdq u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Back: compact unknowns and queue results
    smuc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_rd_data),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign kind        = res.kind;
    assign out_seq     = res.key[KEY_W-1:LOC_W];
    assign out_loc     = res.key[LOC_W-1:0];
    assign out_allele  = res.allele;
    assign out_product = res.product;
    assign out_strain  = res.strain;
    assign last        = res.last;

endmodule

FILE: tb/sv/sorted_merge_with_unknown_compaction_test.sv
// Self-checking testbench for sorted_merge_with_unknown_compaction.
// Depends on smuc_pkg and the top level; runs a directed table, then random merge files.
module sorted_merge_with_unknown_compaction_test;
    import smuc_pkg::*;

    // Register addresses on the configuration port
    localparam logic [2:0] STRAIN_A_ADDR = 3'h0;
    localparam logic [2:0] STRAIN_B_ADDR = 3'h4;

    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 72;
    // Cycles the block may still be busy once the last expected row is out
    localparam int DRAIN_CYCLES   = 32;
    // Cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    // How a directed row is checked: by the merge model, or against a typed echo
    typedef enum logic [1:0] {
        CHECK_MODEL,
        CHECK_ECHO_REJECT,
        CHECK_ECHO_ALLELE
    } check_t;

    typedef struct {
        logic [1:0]               op;
        logic [SEQ_W-1:0]         seq;
        logic [LOC_W-1:0]         loc;
        logic [ALLELE_W-1:0]      allele;
        logic signed [PROD_W-1:0] product;
        logic [STRAIN_W-1:0]      strain;
    } row_item_t;

    typedef struct {
        row_item_t item;
        check_t    chk;
    } directed_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        push;
    logic                        full;
    logic [1:0]                  op;
    logic [SEQ_W-1:0]            seq;
    logic [LOC_W-1:0]            loc;
    logic [ALLELE_W-1:0]         allele;
    logic signed [PROD_W-1:0]    product;
    logic [STRAIN_W-1:0]         strain;
    logic                        empty;
    logic                        pop;
    logic [1:0]                  kind;
    logic [SEQ_W-1:0]            out_seq;
    logic [LOC_W-1:0]            out_loc;
    logic [ALLELE_W-1:0]         out_allele;
    logic signed [PROD_W-1:0]    out_product;
    logic [STRAIN_W-1:0]         out_strain;
    logic                        last;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [2:0]                  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;

    // Merge model state: one head per source, stream ends, running unknown count
    logic                        head_full [2];
    key_t                        head_key [2];
    logic [ALLELE_W-1:0]         head_allele [2];
    logic signed [PROD_W-1:0]    head_product [2];
    logic [STRAIN_W-1:0]         head_strain [2];
    logic                        stream_done [2];
    key_t                        prev_key;
    logic [STRAIN_W-1:0]         unknown_tally;
    logic [STRAIN_W-1:0]         strain_override [2];

    // Rows produced by the item being modelled, and rows still owed by the block
    res_t                        step_rows [$];
    res_t                        pending_rows [$];
    directed_row_t               directed_rows [$];

    int                          mismatch_count;
    int                          burst_left;
    int                          random_items;
    int                          file_no;
    int                          idle_cycles;

    // Receiver stall pattern
    int                          sink_mode;
    int                          sink_mode_left;
    int                          sink_period;
    int                          sink_duty;
    int                          sink_phase;

    sorted_merge_with_unknown_compaction dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .seq         (seq),
        .loc         (loc),
        .allele      (allele),
        .product     (product),
        .strain      (strain),
        .empty       (empty),
        .pop         (pop),
        .kind        (kind),
        .out_seq     (out_seq),
        .out_loc     (out_loc),
        .out_allele  (out_allele),
        .out_product (out_product),
        .out_strain  (out_strain),
        .last        (last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Merge model
    // ------------------------------------------------------------------

    // Return the merge to its empty state; the strain registers survive this
    task automatic clear_merge_state();
        for (int s = 0; s < 2; s++)
        begin
            head_full[s]   = 1'b0;
            stream_done[s] = 1'b0;
        end
        prev_key      = NO_KEY;
        unknown_tally = '0;
    endtask

    task automatic emit_row(input logic [1:0] k, input key_t key,
                            input logic [ALLELE_W-1:0] al,
                            input logic signed [PROD_W-1:0] pr,
                            input logic [STRAIN_W-1:0] st);
        res_t r;
        r.kind    = k;
        r.key     = key;
        r.allele  = al;
        r.product = pr;
        r.strain  = st;
        r.last    = 1'b0;
        step_rows.push_back(r);
    endtask

    // Emit the compacted row for the previous key if any unknowns piled up
    task automatic flush_unknowns();
        if (unknown_tally != '0)
            emit_row(KIND_UNKNOWN, prev_key, '0, PRODUCT_COUNT, unknown_tally);
    endtask

    // Release one head into the output stream or into the unknown count
    task automatic retire_head(input int s);
        int sum;
        if (head_key[s] != prev_key)
        begin
            flush_unknowns();
            prev_key      = head_key[s];
            unknown_tally = '0;
        end
        if (head_allele[s] != '0)
            emit_row(KIND_ALLELE, head_key[s], head_allele[s], head_product[s],
                     head_strain[s]);
        else
        begin
            // A count row carries its own tally; any other unknown counts once
            sum = int'(unknown_tally) +
                  ((head_product[s] == PRODUCT_COUNT) ? int'(head_strain[s]) : 1);
            unknown_tally = (sum > int'(COUNT_MAX)) ? COUNT_MAX : sum[STRAIN_W-1:0];
        end
        head_full[s] = 1'b0;
    endtask

    // Work out every row that one accepted item causes, into step_rows
    task automatic merge_predict(input row_item_t it);
        int                  s;
        logic                is_row;
        logic                refuse;
        logic                busy;
        step_rows.delete();
        s      = int'(it.op[0]);
        is_row = (it.op == OP_ROW_A) || (it.op == OP_ROW_B);
        refuse = is_row ? (head_full[s] || stream_done[s]) : stream_done[s];
        if (refuse)
            emit_row(KIND_REJECT, {it.seq, it.loc}, it.allele, it.product, it.strain);
        else
        begin
            if (is_row)
            begin
                head_key[s]     = {it.seq, it.loc};
                head_allele[s]  = it.allele;
                head_product[s] = it.product;
                head_strain[s]  = (strain_override[s] != '0) ? strain_override[s]
                                                             : it.strain;
                head_full[s]    = 1'b1;
            end
            else
                stream_done[s] = 1'b1;
            // Drain heads while the order between them is settled; A wins a tie
            busy = 1'b1;
            while (busy)
            begin
                if (head_full[0] && head_full[1])
                    retire_head((head_key[1] < head_key[0]) ? 1 : 0);
                else if (head_full[0] && stream_done[1])
                    retire_head(0);
                else if (head_full[1] && stream_done[0])
                    retire_head(1);
                else
                    busy = 1'b0;
            end
            // Both streams over: final compaction, then start afresh
            if (stream_done[0] && stream_done[1] && !head_full[0] && !head_full[1])
            begin
                flush_unknowns();
                clear_merge_state();
            end
        end
        if (step_rows.size() > 0)
            step_rows[step_rows.size()-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // Compare one popped row with the oldest expectation
    task automatic check_result();
        res_t want;
        if (pending_rows.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected row: kind %0d seq 0x%0h loc 0x%0h strain 0x%0h",
                         kind, out_seq, out_loc, out_strain);
        end
        else
        begin
            want = pending_rows.pop_front();
            compare_field("kind",        {want.kind},                 {kind});
            compare_field("out_seq",     {want.key[KEY_W-1:LOC_W]},  {out_seq});
            compare_field("out_loc",     {want.key[LOC_W-1:0]},      {out_loc});
            compare_field("out_allele",  {want.allele},               {out_allele});
            compare_field("out_product", {want.product},              {out_product});
            compare_field("out_strain",  {want.strain},               {out_strain});
            compare_field("last",        {want.last},                 {last});
        end
    endtask

    // Receiver: pick pop at the falling edge, check each transfer at the rising edge.
    // The stall pattern changes mode now and then: always ready, coin toss, or a
    // periodic duty cycle.
    initial
    begin
        pop            = 1'b0;
        sink_mode      = 0;
        sink_mode_left = 0;
        sink_period    = 1;
        sink_duty      = 1;
        sink_phase     = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_mode_left == 0)
            begin
                sink_mode      = $urandom_range(0, 2);
                sink_mode_left = $urandom_range(20, 80);
                sink_period    = $urandom_range(2, 12);
                sink_duty      = $urandom_range(1, sink_period - 1);
                sink_phase     = 0;
            end
            sink_mode_left--;
            sink_phase = (sink_phase + 1) % sink_period;
            case (sink_mode)
                0:       pop = 1'b1;
                1:       pop = 1'($urandom_range(0, 1));
                default: pop = (sink_phase < sink_duty);
            endcase
            @(posedge clk);
            if (pop && !empty)
                check_result();
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one item, hold it until the transfer, then record what it owes.
    // Bursts of random length are separated by random gaps with push low.
    task automatic send_item(input row_item_t it, input check_t chk);
        int   gap;
        res_t echo;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(5, 12);
                default: gap = $urandom_range(1, 3);
            endcase
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(1, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                push = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        push    = 1'b1;
        op      = it.op;
        seq     = it.seq;
        loc     = it.loc;
        allele  = it.allele;
        product = it.product;
        strain  = it.strain;
        do @(posedge clk); while (full);
        merge_predict(it);
        if (chk == CHECK_MODEL)
        begin
            foreach (step_rows[i])
                pending_rows.push_back(step_rows[i]);
        end
        else
        begin
            // Typed expectation: one row that echoes the item
            echo.kind    = (chk == CHECK_ECHO_REJECT) ? KIND_REJECT : KIND_ALLELE;
            echo.key     = {it.seq, it.loc};
            echo.allele  = it.allele;
            echo.product = it.product;
            echo.strain  = it.strain;
            echo.last    = 1'b1;
            pending_rows.push_back(echo);
        end
        burst_left--;
    endtask

    // Drop push, wait for every owed row, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        push = 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Setup then access phase; the register takes the value on the access transfer
    task automatic write_strain_reg(input logic [2:0] addr,
                                    input logic [STRAIN_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == STRAIN_A_ADDR)
            strain_override[0] = value;
        else
            strain_override[1] = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic add_directed(input logic [1:0] o, input logic [SEQ_W-1:0] sq,
                                input logic [LOC_W-1:0] lc,
                                input logic [ALLELE_W-1:0] al,
                                input logic signed [PROD_W-1:0] pr,
                                input logic [STRAIN_W-1:0] st, input check_t chk);
        directed_row_t d;
        d.item.op      = o;
        d.item.seq     = sq;
        d.item.loc     = lc;
        d.item.allele  = al;
        d.item.product = pr;
        d.item.strain  = st;
        d.chk          = chk;
        directed_rows.push_back(d);
    endtask

    // Directed table, walked with both strain registers at zero
    task automatic build_directed();
        // Equal keys on both heads, full-head refusals, count saturation
        add_directed(OP_ROW_A, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        add_directed(OP_ROW_A, 15'd0, 31'd0, 8'd255, 8'sd127, 15'd32767,
                     CHECK_ECHO_REJECT);
        add_directed(OP_ROW_B, 15'd0, 31'd0, 8'd1, 8'sd5, 15'd7, CHECK_MODEL);
        add_directed(OP_ROW_B, 15'd0, 31'd1, 8'd2, -8'sd128, 15'd0, CHECK_ECHO_REJECT);
        add_directed(OP_ROW_A, 15'd0, 31'd0, 8'd0, PRODUCT_COUNT, 15'd32767, CHECK_MODEL);
        add_directed(OP_END_A, 15'd3, 31'd9, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        // Second end of A, and a row after the end of A
        add_directed(OP_END_A, 15'd32767, 31'h7FFFFFFF, 8'd255, -8'sd1, 15'd32767,
                     CHECK_ECHO_REJECT);
        add_directed(OP_ROW_A, 15'd5, 31'd5, 8'd3, 8'sd1, 15'd2, CHECK_ECHO_REJECT);
        add_directed(OP_ROW_B, 15'd32767, 31'h7FFFFFFF, 8'd0, 8'sd0, 15'd9, CHECK_MODEL);
        add_directed(OP_END_B, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        // All-ones key straight after a flush: no compaction ahead of it
        add_directed(OP_END_A, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        add_directed(OP_ROW_B, 15'd32767, 31'h7FFFFFFF, 8'd0, PRODUCT_COUNT, 15'd4,
                     CHECK_MODEL);
        add_directed(OP_ROW_B, 15'd32767, 31'h7FFFFFFF, 8'd77, 8'sd127, 15'd32767,
                     CHECK_MODEL);
        add_directed(OP_END_B, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        // Pass-through once B has ended, and a repeated end of B
        add_directed(OP_END_B, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        add_directed(OP_ROW_A, 15'd100, 31'd5, 8'd200, -8'sd128, 15'd1234,
                     CHECK_ECHO_ALLELE);
        add_directed(OP_END_B, 15'd21845, 31'h2AAAAAAA, 8'hAA, 8'sh55, 15'h2AAA,
                     CHECK_ECHO_REJECT);
        add_directed(OP_END_A, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        // Unknowns on both sources, a key change forcing a compaction mid-stream
        add_directed(OP_ROW_B, 15'd1, 31'd10, 8'd0, 8'sd3, 15'd0, CHECK_MODEL);
        add_directed(OP_ROW_A, 15'd1, 31'd10, 8'd0, PRODUCT_COUNT, 15'd6, CHECK_MODEL);
        add_directed(OP_ROW_A, 15'd1, 31'd11, 8'd9, 8'sd1, 15'd100, CHECK_MODEL);
        add_directed(OP_END_B, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
        add_directed(OP_END_A, 15'd0, 31'd0, 8'd0, 8'sd0, 15'd0, CHECK_MODEL);
    endtask

    // Any op with fully random fields
    function automatic row_item_t noise_item();
        row_item_t it;
        it.op      = 2'($urandom_range(0, 3));
        it.seq     = SEQ_W'($urandom());
        it.loc     = LOC_W'($urandom());
        it.allele  = ALLELE_W'($urandom());
        it.product = PROD_W'($urandom());
        it.strain  = STRAIN_W'($urandom());
        return it;
    endfunction

    // A well-formed row for one source at the given key
    function automatic row_item_t lane_row(input int s, input key_t key);
        row_item_t it;
        it.op      = (s == 1) ? OP_ROW_B : OP_ROW_A;
        it.seq     = key[KEY_W-1:LOC_W];
        it.loc     = key[LOC_W-1:0];
        it.allele  = ($urandom_range(0, 1) == 0) ? '0 : ALLELE_W'($urandom_range(1, 255));
        if (it.allele == '0 && $urandom_range(0, 2) == 0)
            it.product = PRODUCT_COUNT;
        else
            it.product = PROD_W'($urandom());
        if (it.product == PRODUCT_COUNT && $urandom_range(0, 9) != 0)
            it.strain = STRAIN_W'($urandom_range(1, 5));
        else
            it.strain = STRAIN_W'($urandom_range(0, 32767));
        return it;
    endfunction

    // One merge file: two sorted lanes sent in random order, then both ends,
    // with a sprinkling of random items that break the sequence.
    task automatic run_random_file();
        row_item_t lane_a [$];
        row_item_t lane_b [$];
        row_item_t it;
        key_t      base;
        key_t      key;
        key_t      step;
        key_t      next_key;
        logic      done_a;
        logic      done_b;
        logic      can_a;
        logic      can_b;
        int        n;
        case ($urandom_range(0, 9))
            6, 7:    base = key_t'({$urandom(), $urandom()});
            8, 9:    base = NO_KEY - key_t'($urandom_range(0, 30));
            default: base = {SEQ_W'($urandom_range(0, 3)), LOC_W'($urandom_range(0, 20))};
        endcase
        for (int s = 0; s < 2; s++)
        begin
            key = base + key_t'($urandom_range(0, 3));
            if (key < base)
                key = NO_KEY;
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: step = '0;
                    8, 9:       step = key_t'(1) << LOC_W;
                    default:    step = key_t'($urandom_range(1, 3));
                endcase
                next_key = key + step;
                key = (next_key < key) ? NO_KEY : next_key;
                if (s == 0)
                    lane_a.push_back(lane_row(0, key));
                else
                    lane_b.push_back(lane_row(1, key));
            end
        end
        done_a = 1'b0;
        done_b = 1'b0;
        while (!(done_a && done_b))
        begin
            // Abandon a lane that a stray end has closed
            if (stream_done[0] && !done_a)
            begin
                lane_a.delete();
                done_a = 1'b1;
            end
            if (stream_done[1] && !done_b)
            begin
                lane_b.delete();
                done_b = 1'b1;
            end
            can_a = !done_a && !head_full[0];
            can_b = !done_b && !head_full[1];
            if ($urandom_range(0, 9) == 0)
                it = noise_item();
            else if (can_a && (!can_b || $urandom_range(0, 1) == 0))
            begin
                if (lane_a.size() != 0)
                    it = lane_a.pop_front();
                else
                begin
                    it = noise_item();
                    it.op = OP_END_A;
                    done_a = 1'b1;
                end
            end
            else if (can_b)
            begin
                if (lane_b.size() != 0)
                    it = lane_b.pop_front();
                else
                begin
                    it = noise_item();
                    it.op = OP_END_B;
                    done_b = 1'b1;
                end
            end
            else
            begin
                // Head stuck after a stray reset of the merge: end the free side
                it = noise_item();
                if (!head_full[0] && !stream_done[0])
                begin
                    it.op = OP_END_A;
                    done_a = 1'b1;
                end
                else
                begin
                    it.op = OP_END_B;
                    done_b = 1'b1;
                end
            end
            send_item(it, CHECK_MODEL);
            random_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n    = 1'b0;
        push     = 1'b0;
        op       = OP_ROW_A;
        seq      = '0;
        loc      = '0;
        allele   = '0;
        product  = '0;
        strain   = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mismatch_count     = 0;
        burst_left         = 0;
        random_items       = 0;
        file_no            = 0;
        strain_override[0] = '0;
        strain_override[1] = '0;
        clear_merge_state();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_strain_reg(STRAIN_A_ADDR, '0);
        write_strain_reg(STRAIN_B_ADDR, '0);

        build_directed();
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].chk);

        // Random files; change the strain registers every second file while idle
        while (random_items < RANDOM_ITEMS)
        begin
            if (file_no % 2 == 0)
            begin
                wait_idle();
                case ((file_no / 2) % 5)
                    0:
                    begin
                        write_strain_reg(STRAIN_A_ADDR, COUNT_MAX);
                        write_strain_reg(STRAIN_B_ADDR, 15'd1);
                    end
                    1:
                    begin
                        write_strain_reg(STRAIN_A_ADDR, '0);
                        write_strain_reg(STRAIN_B_ADDR, COUNT_MAX);
                    end
                    2:
                    begin
                        write_strain_reg(STRAIN_A_ADDR, STRAIN_W'($urandom_range(0, 32767)));
                        write_strain_reg(STRAIN_B_ADDR, STRAIN_W'($urandom_range(0, 32767)));
                    end
                    3:
                    begin
                        write_strain_reg(STRAIN_A_ADDR, 15'd1);
                        write_strain_reg(STRAIN_B_ADDR, '0);
                    end
                    default:
                    begin
                        write_strain_reg(STRAIN_A_ADDR, '0);
                        write_strain_reg(STRAIN_B_ADDR, '0);
                    end
                endcase
            end
            run_random_file();
            file_no++;
        end

        wait_idle();
        if (mismatch_count == 0 && pending_rows.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/smuc_pkg.sv
rtl/smuc_front.sv
rtl/smuc_cmdq.sv
rtl/smuc_back.sv
rtl/sorted_merge_with_unknown_compaction.sv
tb/sv/sorted_merge_with_unknown_compaction_test.sv
